// ===== rtl/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher block.
// Used by the controller, the datapath and the top level; depends on nothing.
package rc4_pkg;

    localparam int MAX_KEY_BYTES = 256;
    localparam int PERM_DEPTH    = 256;
    localparam int BYTE_W        = 8;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Datapath operations, one per controller step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SINIT,
        OP_K0,
        OP_K1,
        OP_K2,
        OP_K3,
        OP_D0,
        OP_D1,
        OP_D2,
        OP_D3,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic n_last;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/rc4_in_if.sv =====
// Input channel of the RC4 block: valid/ready handshake with a key or data item.
// Depends on nothing.
interface rc4_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ===== rtl/rc4_out_if.sv =====
// Output channel of the RC4 block: valid/ready handshake with a result item.
// Depends on nothing.
interface rc4_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       last_out;

    modport source (output valid, output data_out, output last_out, input ready);
    modport sink   (input valid, input data_out, input last_out, output ready);
endinterface

// ===== rtl/rc4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// A read of the address written in the same cycle returns the old contents.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rc4_ctrl.sv =====
// Controller of the RC4 block: sequences item intake, the key schedule and the
// keystream step. Depends on rc4_pkg.
module rc4_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_kind,
    input  logic          in_last,
    output logic          in_ready,
    output rc4_pkg::cmd_t cmd,
    input  rc4_pkg::sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SINIT,
        S_K0,
        S_K1,
        S_K2,
        S_K3,
        S_D0,
        S_D1,
        S_D2,
        S_D3,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = rc4_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = rc4_pkg::OP_LOAD;
                    if (in_kind == rc4_pkg::KIND_DATA)
                    begin
                        state_next = S_D0;
                    end
                    else if (in_last)
                    begin
                        state_next = S_SINIT;
                    end
                end
            end
            S_SINIT:
            begin
                cmd.op     = rc4_pkg::OP_SINIT;
                state_next = S_K0;
            end
            S_K0:
            begin
                cmd.op     = rc4_pkg::OP_K0;
                state_next = S_K1;
            end
            S_K1:
            begin
                cmd.op     = rc4_pkg::OP_K1;
                state_next = S_K2;
            end
            S_K2:
            begin
                cmd.op     = rc4_pkg::OP_K2;
                state_next = S_K3;
            end
            S_K3:
            begin
                cmd.op     = rc4_pkg::OP_K3;
                state_next = sts.n_last ? S_IDLE : S_K0;
            end
            S_D0:
            begin
                cmd.op     = rc4_pkg::OP_D0;
                state_next = S_D1;
            end
            S_D1:
            begin
                cmd.op     = rc4_pkg::OP_D1;
                state_next = S_D2;
            end
            S_D2:
            begin
                cmd.op     = rc4_pkg::OP_D2;
                state_next = S_D3;
            end
            S_D3:
            begin
                cmd.op     = rc4_pkg::OP_D3;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = rc4_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== rtl/rc4_datapath.sv =====
// Datapath of the RC4 block: permutation and key memories, indices, key count
// and the result register. Depends on rc4_pkg and rc4_ram.
module rc4_datapath #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  rc4_pkg::cmd_t cmd,
    output rc4_pkg::sts_t sts,
    input  logic          in_kind,
    input  logic [7:0]    in_value,
    input  logic          in_last,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_data,
    output logic          out_last
);

    localparam int CW = $clog2(MAX_KEY_BYTES + 1);
    localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    // Control state.
    logic [rc4_pkg::PERM_DEPTH-1:0] pvalid_reg;
    logic [7:0]    i_reg;
    logic [7:0]    j_reg;
    logic [7:0]    jacc_reg;
    logic [7:0]    n_reg;
    logic [CW-1:0] cnt_reg;
    logic [KW-1:0] k_reg;
    logic          out_valid_reg;

    // Payload.
    logic [7:0] value_reg;
    logic       last_reg;
    logic [7:0] sx_reg;
    logic [7:0] sy_reg;
    logic [7:0] a_reg;
    logic [7:0] res_reg;
    logic       rvalid_reg;
    logic [7:0] raddr_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;

    logic          p_we;
    logic [7:0]    p_waddr;
    logic [7:0]    p_wdata;
    logic [7:0]    p_raddr;
    logic [7:0]    p_rdata;
    logic [7:0]    p_val;
    logic          k_we;
    logic [7:0]    k_rdata;
    logic [7:0]    ks;
    logic          key_room;
    logic [CW-1:0] key_len;
    logic [CW:0]   k_inc;

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (rc4_pkg::PERM_DEPTH)
    ) u_perm_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (MAX_KEY_BYTES)
    ) u_key_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (cnt_reg[KW-1:0]),
        .wdata (in_value),
        .raddr (k_reg),
        .rdata (k_rdata)
    );

    // An entry not written since reset or since the schedule began holds its own index.
    assign p_val = rvalid_reg ? p_rdata : raddr_reg;

    assign key_room = (cnt_reg < CW'(MAX_KEY_BYTES));
    assign key_len  = (cnt_reg == '0) ? CW'(1) : cnt_reg;
    assign k_inc    = (CW + 1)'(k_reg) + (CW + 1)'(1);
    assign k_we     = (cmd.op == rc4_pkg::OP_LOAD) && (in_kind == rc4_pkg::KIND_KEY) && key_room;

    always_comb
    begin
        p_raddr = n_reg;
        p_we    = 1'b0;
        p_waddr = n_reg;
        p_wdata = p_val;
        case (cmd.op)
            rc4_pkg::OP_D0: p_raddr = i_reg + 8'd1;
            rc4_pkg::OP_D1: p_raddr = j_reg + p_val;
            rc4_pkg::OP_D2:
            begin
                p_raddr = sx_reg + p_val;
                p_we    = 1'b1;
                p_waddr = i_reg;
                p_wdata = p_val;
            end
            rc4_pkg::OP_D3:
            begin
                p_we    = 1'b1;
                p_waddr = j_reg;
                p_wdata = sx_reg;
            end
            rc4_pkg::OP_K1: p_raddr = jacc_reg + k_rdata + p_val;
            rc4_pkg::OP_K2:
            begin
                p_we    = 1'b1;
                p_waddr = n_reg;
                p_wdata = p_val;
            end
            rc4_pkg::OP_K3:
            begin
                p_we    = 1'b1;
                p_waddr = jacc_reg;
                p_wdata = a_reg;
            end
            default:
            begin
                p_raddr = n_reg;
            end
        endcase
    end

    // The keystream entry was read before the swap completed; the swapped
    // entries are forwarded, with the j side taking precedence.
    always_comb
    begin
        if (raddr_reg == j_reg)
        begin
            ks = sx_reg;
        end
        else if (raddr_reg == i_reg)
        begin
            ks = sy_reg;
        end
        else
        begin
            ks = p_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg    <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            jacc_reg      <= '0;
            n_reg         <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == rc4_pkg::OP_SINIT)
            begin
                pvalid_reg <= '0;
            end
            else if (p_we)
            begin
                pvalid_reg[p_waddr] <= 1'b1;
            end

            if (cmd.op == rc4_pkg::OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (cmd.op)
                rc4_pkg::OP_LOAD:
                begin
                    if (k_we)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                rc4_pkg::OP_SINIT:
                begin
                    i_reg    <= '0;
                    j_reg    <= '0;
                    jacc_reg <= '0;
                    n_reg    <= '0;
                    k_reg    <= '0;
                end
                rc4_pkg::OP_K1: jacc_reg <= p_raddr;
                rc4_pkg::OP_K3:
                begin
                    n_reg <= n_reg + 8'd1;
                    if (k_inc >= (CW + 1)'(key_len))
                    begin
                        k_reg <= '0;
                    end
                    else
                    begin
                        k_reg <= k_inc[KW-1:0];
                    end
                    if (n_reg == rc4_pkg::BYTE_MAX)
                    begin
                        cnt_reg <= '0;
                    end
                end
                rc4_pkg::OP_D1:
                begin
                    i_reg <= i_reg + 8'd1;
                    j_reg <= p_raddr;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rvalid_reg <= pvalid_reg[p_raddr];
        raddr_reg  <= p_raddr;
        case (cmd.op)
            rc4_pkg::OP_LOAD:
            begin
                value_reg <= in_value;
                last_reg  <= in_last;
            end
            rc4_pkg::OP_K1: a_reg   <= p_val;
            rc4_pkg::OP_D1: sx_reg  <= p_val;
            rc4_pkg::OP_D2: sy_reg  <= p_val;
            rc4_pkg::OP_D3: res_reg <= value_reg ^ ks;
            rc4_pkg::OP_OUT:
            begin
                out_data_reg <= res_reg;
                out_last_reg <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.n_last   = (n_reg == rc4_pkg::BYTE_MAX);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/rc4_stream_cipher_top.sv =====
// RC4 stream cipher top level. A key item is taken in S_IDLE; the item that ends the key
// adds the schedule: S_SINIT for setup, then 256 mixing steps, each through S_K0 to S_K3,
// as the permutation memory has a single read and a single write port. A data item
// passes through S_D0 to S_D3, then S_OUT waits until the output register is free; the
// next item is taken after S_OUT, while the result may still wait in the output register.
// After reset the permutation is identity with both indices zero, no clearing pass.
module rc4_stream_cipher_top #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    rc4_in_if.sink     rx,
    rc4_out_if.source  tx
);

    rc4_pkg::cmd_t cmd;
    rc4_pkg::sts_t sts;

    rc4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_kind  (rx.kind),
        .in_last  (rx.last),
        .in_ready (rx.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rc4_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_kind   (rx.kind),
        .in_value  (rx.value),
        .in_last   (rx.last),
        .out_valid (tx.valid),
        .out_ready (tx.ready),
        .out_data  (tx.data_out),
        .out_last  (tx.last_out)
    );

endmodule

// ===== bench/rc4_stream_cipher_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for rc4_stream_cipher_top: directed and random key loads and data blocks in,
// each cipher byte checked against an in-bench RC4 keystream.
// Needs rc4_pkg and both channel interfaces.
module rc4_stream_cipher_top_test;

    localparam int IDLE_LIMIT    = 8000;
    localparam int TAIL_CYCLES   = 1100;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int SHOWN_FAULTS  = 10;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
        logic       drain;
    } cipher_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cipher_byte_t;

    logic clk;
    logic rst_n;

    rc4_in_if  rx_if ();
    rc4_out_if tx_if ();

    rc4_stream_cipher_top #(
        .MAX_KEY_BYTES(rc4_pkg::MAX_KEY_BYTES)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .rx   (rx_if),
        .tx   (tx_if)
    );

    cipher_item_t item_q[$];
    cipher_byte_t cipher_q[$];

    // Keystream state kept by the bench.
    logic [7:0]  sbox [256];
    logic [7:0]  idx_i;
    logic [7:0]  idx_j;
    logic [7:0]  key_mem [256];
    int unsigned key_len;

    int  fault_count;
    int  idle_cycles;
    int  queued;
    logic in_fire;
    int  burst_left;
    int  gap_left;
    int  rx_cycle;
    int  ready_mode;

    always #4 clk = ~clk;

    function automatic void clear_cipher_state();
        for (int n = 0; n < 256; n++)
        begin
            sbox[n]    = 8'(n);
            key_mem[n] = 8'h00;
        end
        idx_i   = 8'h00;
        idx_j   = 8'h00;
        key_len = 0;
    endfunction

    function automatic void schedule_key();
        int unsigned span;
        int unsigned k;
        logic [7:0]  jj;
        logic [7:0]  tmp;
        span = (key_len == 0) ? 1 : key_len;
        for (int n = 0; n < 256; n++)
            sbox[n] = 8'(n);
        idx_i = 8'h00;
        idx_j = 8'h00;
        jj    = 8'h00;
        k     = 0;
        for (int n = 0; n < 256; n++)
        begin
            tmp      = sbox[n];
            jj       = jj + key_mem[k[7:0]] + tmp;
            sbox[n]  = sbox[jj];
            sbox[jj] = tmp;
            k++;
            if (k >= span)
                k = 0;
        end
        key_len = 0;
    endfunction

    function automatic logic [7:0] keystream_byte();
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sx;
        logic [7:0] sy;
        logic [7:0] t;
        x       = idx_i + 8'd1;
        sx      = sbox[x];
        y       = idx_j + sx;
        sy      = sbox[y];
        idx_i   = x;
        idx_j   = y;
        sbox[y] = sx;
        sbox[x] = sy;
        t       = sx + sy;
        return sbox[t];
    endfunction

    // Applies one accepted item to the bench state; a data item queues its cipher byte.
    function automatic void absorb_item(logic kind, logic [7:0] value, logic last);
        cipher_byte_t cb;
        if (kind == rc4_pkg::KIND_KEY)
        begin
            if (key_len < rc4_pkg::MAX_KEY_BYTES)
            begin
                key_mem[key_len[7:0]] = value;
                key_len++;
            end
            if (last)
                schedule_key();
        end
        else
        begin
            cb.data = value ^ keystream_byte();
            cb.last = last;
            cipher_q.push_back(cb);
        end
    endfunction

    function automatic void report_fault(string msg);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic void push_item(logic kind, logic [7:0] value, logic last, logic drain);
        cipher_item_t it;
        it.kind  = kind;
        it.value = value;
        it.last  = last;
        it.drain = drain;
        item_q.push_back(it);
        queued++;
    endfunction

    // A key of len bytes; when mixed, data bytes are slipped in while the key is loading.
    function automatic void add_key(int len, bit mixed, logic drain);
        for (int b = 0; b < len; b++)
        begin
            push_item(rc4_pkg::KIND_KEY, 8'($urandom), b == len - 1, drain && b == 0);
            if (mixed && b != len - 1 && $urandom_range(0, 3) == 0)
                push_item(rc4_pkg::KIND_DATA, 8'($urandom), 1'($urandom), 1'b0);
        end
    endfunction

    function automatic void add_block(int len, logic drain);
        for (int b = 0; b < len; b++)
            push_item(rc4_pkg::KIND_DATA, 8'($urandom), b == len - 1, drain && b == 0);
    endfunction

    function automatic int pick_key_len(int seq_n);
        int r;
        r = $urandom_range(0, 19);
        if (seq_n == 2 || r == 0)
            return rc4_pkg::MAX_KEY_BYTES;
        if (seq_n == 5 || r == 1)
            return $urandom_range(rc4_pkg::MAX_KEY_BYTES + 1, rc4_pkg::MAX_KEY_BYTES + 64);
        return $urandom_range(1, 16);
    endfunction

    // Driver: after the current item is taken and any gap ends, presents the next; drain items wait for all results.
    always @(negedge clk)
    begin
        if (rst_n && (!rx_if.valid || in_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                rx_if.valid <= 1'b0;
            end
            else if (item_q.size() == 0)
                rx_if.valid <= 1'b0;
            else if (item_q[0].drain && cipher_q.size() != 0)
                rx_if.valid <= 1'b0;
            else
            begin
                cipher_item_t it;
                it = item_q.pop_front();
                rx_if.kind  <= it.kind;
                rx_if.value <= it.value;
                rx_if.last  <= it.last;
                rx_if.valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                    burst_left--;
            end
        end
    end

    // Receiver stalls follow a randomly drawn mode: always ready, mostly ready, mostly stalled or a fixed pattern.
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 256 == 0)
            ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0: tx_if.ready <= 1'b1;
            1: tx_if.ready <= ($urandom_range(0, 3) != 0);
            2: tx_if.ready <= ($urandom_range(0, 3) == 0);
            default: tx_if.ready <= (rx_cycle % 5 != 0) && (rx_cycle % 64 < 40);
        endcase
    end

    // Monitor: updates the prediction on every accepted input and checks every result.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= rx_if.valid && rx_if.ready;
            if (rx_if.valid && rx_if.ready)
                absorb_item(rx_if.kind, rx_if.value, rx_if.last);
            if (tx_if.valid && tx_if.ready)
            begin
                if (cipher_q.size() == 0)
                    report_fault($sformatf("unexpected result data_out=%02h last_out=%0b",
                                           tx_if.data_out, tx_if.last_out));
                else
                begin
                    cipher_byte_t cb;
                    cb = cipher_q.pop_front();
                    if (tx_if.data_out !== cb.data)
                        report_fault($sformatf("data_out mismatch: expected %02h, got %02h",
                                               cb.data, tx_if.data_out));
                    if (tx_if.last_out !== cb.last)
                        report_fault($sformatf("last_out mismatch: expected %0b, got %0b",
                                               cb.last, tx_if.last_out));
                end
            end
            if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int seq_n;
        int r;
        logic drain;
        clk         = 1'b0;
        rst_n       = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.kind  = rc4_pkg::KIND_KEY;
        rx_if.value = 8'h00;
        rx_if.last  = 1'b0;
        tx_if.ready = 1'b0;
        fault_count = 0;
        idle_cycles = 0;
        queued      = 0;
        in_fire     = 1'b0;
        burst_left  = 1;
        gap_left    = 0;
        rx_cycle    = 0;
        ready_mode  = 0;
        clear_cipher_state();

        // Data before any key runs on the identity permutation.
        push_item(rc4_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0);
        push_item(rc4_pkg::KIND_DATA, 8'hFF, 1'b0, 1'b0);
        push_item(rc4_pkg::KIND_DATA, 8'h5A, 1'b1, 1'b0);
        // Data while a key is half loaded uses the current permutation.
        push_item(rc4_pkg::KIND_KEY,  8'h00, 1'b0, 1'b0);
        push_item(rc4_pkg::KIND_DATA, 8'h3C, 1'b0, 1'b0);
        push_item(rc4_pkg::KIND_KEY,  8'hFF, 1'b1, 1'b0);
        push_item(rc4_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0);
        push_item(rc4_pkg::KIND_DATA, 8'hFF, 1'b0, 1'b0);
        push_item(rc4_pkg::KIND_DATA, 8'hA5, 1'b1, 1'b0);
        // Single-byte key.
        push_item(rc4_pkg::KIND_KEY,  8'h80, 1'b1, 1'b0);
        push_item(rc4_pkg::KIND_DATA, 8'hFF, 1'b0, 1'b0);
        push_item(rc4_pkg::KIND_DATA, 8'h01, 1'b1, 1'b0);
        push_item(rc4_pkg::KIND_DATA, 8'h00, 1'b1, 1'b1);

        seq_n = 0;
        while (queued < RANDOM_ITEMS + 13)
        begin
            drain = (seq_n == 0) || ($urandom_range(0, 99) < 3);
            r     = $urandom_range(0, 99);
            if (seq_n == 2 || seq_n == 5)
                add_key(pick_key_len(seq_n), 1'b0, drain);
            else if (r < 55)
                add_block(($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 40), drain);
            else if (r < 70)
                add_key(pick_key_len(seq_n), 1'b0, drain);
            else if (r < 78)
                add_key(pick_key_len(seq_n), 1'b1, drain);
            else if (r < 90)
                push_item(rc4_pkg::KIND_DATA, 8'($urandom), 1'($urandom), drain);
            else
            begin
                // Stray key bytes stay pending and lengthen the next key.
                for (int b = $urandom_range(1, 3); b > 0; b--)
                    push_item(rc4_pkg::KIND_KEY, 8'($urandom), 1'b0, drain && b == 1);
            end
            seq_n++;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (item_q.size() != 0 || rx_if.valid || cipher_q.size() != 0)
            @(posedge clk);
        // A trailing key may still be scheduling; let it finish and watch for stray results.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (cipher_q.size() != 0)
            report_fault($sformatf("%0d results never arrived", cipher_q.size()));

        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rc4_pkg.sv
rtl/rc4_in_if.sv
rtl/rc4_out_if.sv
rtl/rc4_ram.sv
rtl/rc4_ctrl.sv
rtl/rc4_datapath.sv
rtl/rc4_stream_cipher_top.sv
bench/rc4_stream_cipher_top_test.sv
